FILE: rtl/core/gpf_pkg.sv
// Shared types and constants for the grid peak finder.
package gpf_pkg;

  localparam int ROWS_MAX_DEF = 64;
  localparam int COLS_MAX_DEF = 64;

  localparam int VALUE_W = 32;
  localparam int CFG_W   = 7;
  localparam int IDX_W   = 6;

  localparam logic [CFG_W-1:0] NUM_ROWS_RST = 7'd64;
  localparam logic [CFG_W-1:0] NUM_COLS_RST = 7'd64;

  // register index as decoded from the address
  localparam logic REG_NUM_ROWS = 1'b0;
  localparam logic REG_NUM_COLS = 1'b1;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CHECK,
    ST_SCAN_A,
    ST_SCAN_B,
    ST_SCAN_C,
    ST_LEFT_A,
    ST_LEFT_B,
    ST_LEFT_C,
    ST_RIGHT_A,
    ST_RIGHT_B,
    ST_RIGHT_C,
    ST_DECIDE,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    RD_SCAN,
    RD_LEFT,
    RD_RIGHT
  } rd_sel_t;

  typedef struct packed {
    logic    load_we;
    logic    search_init;
    logic    mid_calc;
    logic    scan_clear;
    logic    addr_load;
    rd_sel_t rd_sel;
    logic    scan_take;
    logic    left_take;
    logic    left_edge;
    logic    right_take;
    logic    right_edge;
    logic    step_left;
    logic    step_right;
    logic    hit_set;
    logic    hit_clr;
    logic    res_load;
  } cmd_t;

  typedef struct packed {
    logic range_empty;
    logic scan_last;
    logic mid_first;
    logic mid_last;
    logic left_ok;
    logic left_gt;
    logic right_ok;
    logic out_busy;
  } status_t;

endpackage

FILE: rtl/core/gpf_ctrl.sv
// Sequencer for loading the matrix and running the column search.
module gpf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_last,
  output logic             in_ready,
  input  gpf_pkg::status_t status,
  output gpf_pkg::cmd_t    cmd
);

  gpf_pkg::state_t state;
  gpf_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gpf_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = gpf_pkg::RD_SCAN;
    in_ready   = 1'b0;
    unique case (state)
      gpf_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_we = 1'b1;
          if (in_last) begin
            cmd.search_init = 1'b1;
            state_next      = gpf_pkg::ST_CHECK;
          end
        end
      end
      gpf_pkg::ST_CHECK: begin
        if (status.range_empty) begin
          cmd.hit_clr = 1'b1;
          state_next  = gpf_pkg::ST_DONE;
        end else begin
          cmd.mid_calc   = 1'b1;
          cmd.scan_clear = 1'b1;
          state_next     = gpf_pkg::ST_SCAN_A;
        end
      end
      gpf_pkg::ST_SCAN_A: begin
        cmd.addr_load = 1'b1;
        cmd.rd_sel    = gpf_pkg::RD_SCAN;
        state_next    = gpf_pkg::ST_SCAN_B;
      end
      gpf_pkg::ST_SCAN_B: begin
        state_next = gpf_pkg::ST_SCAN_C;
      end
      gpf_pkg::ST_SCAN_C: begin
        cmd.scan_take = 1'b1;
        state_next    = status.scan_last ? gpf_pkg::ST_LEFT_A : gpf_pkg::ST_SCAN_A;
      end
      gpf_pkg::ST_LEFT_A: begin
        if (status.mid_first) begin
          cmd.left_edge = 1'b1;
          state_next    = gpf_pkg::ST_RIGHT_A;
        end else begin
          cmd.addr_load = 1'b1;
          cmd.rd_sel    = gpf_pkg::RD_LEFT;
          state_next    = gpf_pkg::ST_LEFT_B;
        end
      end
      gpf_pkg::ST_LEFT_B: begin
        state_next = gpf_pkg::ST_LEFT_C;
      end
      gpf_pkg::ST_LEFT_C: begin
        cmd.left_take = 1'b1;
        state_next    = gpf_pkg::ST_RIGHT_A;
      end
      gpf_pkg::ST_RIGHT_A: begin
        if (status.mid_last) begin
          cmd.right_edge = 1'b1;
          state_next     = gpf_pkg::ST_DECIDE;
        end else begin
          cmd.addr_load = 1'b1;
          cmd.rd_sel    = gpf_pkg::RD_RIGHT;
          state_next    = gpf_pkg::ST_RIGHT_B;
        end
      end
      gpf_pkg::ST_RIGHT_B: begin
        state_next = gpf_pkg::ST_RIGHT_C;
      end
      gpf_pkg::ST_RIGHT_C: begin
        cmd.right_take = 1'b1;
        state_next     = gpf_pkg::ST_DECIDE;
      end
      gpf_pkg::ST_DECIDE: begin
        priority if (status.left_ok && status.right_ok) begin
          cmd.hit_set = 1'b1;
          state_next  = gpf_pkg::ST_DONE;
        end else if (status.left_gt) begin
          cmd.step_left = 1'b1;
          state_next    = gpf_pkg::ST_CHECK;
        end else begin
          cmd.step_right = 1'b1;
          state_next     = gpf_pkg::ST_CHECK;
        end
      end
      gpf_pkg::ST_DONE: begin
        // hold until the previous result has left the output register
        if (!status.out_busy) begin
          cmd.res_load = 1'b1;
          state_next   = gpf_pkg::ST_LOAD;
        end
      end
      default: begin
        state_next = gpf_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

FILE: rtl/core/gpf_datapath.sv
// Matrix store, search registers, comparators and result register.
module gpf_datapath #(
  parameter int ROWS_MAX = gpf_pkg::ROWS_MAX_DEF,
  parameter int COLS_MAX = gpf_pkg::COLS_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [gpf_pkg::CFG_W-1:0]     num_rows_cfg,
  input  logic [gpf_pkg::CFG_W-1:0]     num_cols_cfg,
  input  logic [gpf_pkg::VALUE_W-1:0]   in_value,
  input  gpf_pkg::cmd_t                 cmd,
  output gpf_pkg::status_t              status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [gpf_pkg::IDX_W-1:0]     out_row,
  output logic [gpf_pkg::IDX_W-1:0]     out_col,
  output logic                          out_found
);

  localparam int DEPTH = ROWS_MAX * COLS_MAX;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RIW   = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
  localparam int CIW   = (COLS_MAX > 1) ? $clog2(COLS_MAX) : 1;
  localparam int RDW   = $clog2(ROWS_MAX + 1);
  localparam int CDW   = $clog2(COLS_MAX + 1);
  localparam int PW    = RIW + CDW + 1;

  logic [gpf_pkg::VALUE_W-1:0] mem [DEPTH];
  logic [gpf_pkg::VALUE_W-1:0] rd_data;
  logic [AW-1:0]               rd_addr;
  logic [AW-1:0]               load_count;

  logic [CDW-1:0] search_low;
  logic [CDW-1:0] search_high;
  logic [CIW-1:0] mid;
  logic [RIW-1:0] row;
  logic [RIW-1:0] best_row;
  logic [gpf_pkg::VALUE_W-1:0] best_val;
  logic           left_ok;
  logic           left_gt;
  logic           right_ok;
  logic           hit;

  logic [31:0]    rows_w;
  logic [31:0]    cols_w;
  logic [31:0]    rows_c;
  logic [31:0]    cols_c;
  logic [RDW-1:0] rows_eff;
  logic [CDW-1:0] cols_eff;
  logic [CDW-1:0] span;
  logic [CDW-1:0] mid_w;
  logic [CDW-1:0] mid_ext;
  logic [CDW-1:0] mid_inc;
  logic [RIW-1:0] row_sel;
  logic [CIW-1:0] col_sel;
  logic [PW-1:0]  addr_calc;
  logic [31:0]    best_row_w;
  logic [31:0]    mid_wide;
  logic           rd_gt_best;
  logic           best_gt_rd;

  // clamp the dimension registers: zero acts as one, oversize as the maximum
  always_comb begin
    rows_w = 32'(num_rows_cfg);
    cols_w = 32'(num_cols_cfg);
    rows_c = (rows_w == 32'd0) ? 32'd1 : ((rows_w > ROWS_MAX) ? 32'(ROWS_MAX) : rows_w);
    cols_c = (cols_w == 32'd0) ? 32'd1 : ((cols_w > COLS_MAX) ? 32'(COLS_MAX) : cols_w);
  end

  assign rows_eff = rows_c[RDW-1:0];
  assign cols_eff = cols_c[CDW-1:0];

  assign span    = CDW'(search_high - search_low - CDW'(1));
  assign mid_w   = CDW'(search_low + (span >> 1));
  assign mid_ext = CDW'(mid);
  assign mid_inc = CDW'(mid_ext + CDW'(1));

  always_comb begin
    unique case (cmd.rd_sel)
      gpf_pkg::RD_SCAN: begin
        row_sel = row;
        col_sel = mid;
      end
      gpf_pkg::RD_LEFT: begin
        row_sel = best_row;
        col_sel = CIW'(mid - CIW'(1));
      end
      gpf_pkg::RD_RIGHT: begin
        row_sel = best_row;
        col_sel = CIW'(mid + CIW'(1));
      end
      default: begin
        row_sel = row;
        col_sel = mid;
      end
    endcase
  end

  assign addr_calc  = PW'(PW'(row_sel) * PW'(cols_eff) + PW'(col_sel));
  assign rd_gt_best = $signed(rd_data) > $signed(best_val);
  assign best_gt_rd = $signed(best_val) > $signed(rd_data);
  assign best_row_w = 32'(best_row);
  assign mid_wide   = 32'(mid);

  // store: one write port for loading, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.load_we) begin
      mem[load_count] <= in_value;
    end
    rd_data <= mem[rd_addr];
    if (cmd.addr_load) begin
      rd_addr <= addr_calc[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count  <= '0;
      search_low  <= '0;
      search_high <= '0;
      best_row    <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.load_we) begin
        if (cmd.search_init || load_count == AW'(DEPTH - 1)) begin
          load_count <= '0;
        end else begin
          load_count <= AW'(load_count + AW'(1));
        end
      end
      if (cmd.search_init) begin
        search_low  <= '0;
        search_high <= cols_eff;
      end
      if (cmd.step_left) begin
        search_high <= mid_ext;
      end
      if (cmd.step_right) begin
        search_low <= mid_inc;
      end
      if (cmd.scan_take && (row == '0 || rd_gt_best)) begin
        best_row <= row;
      end
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mid_calc) begin
      mid <= mid_w[CIW-1:0];
    end
    if (cmd.scan_clear) begin
      row <= '0;
    end else if (cmd.scan_take) begin
      row <= RIW'(row + RIW'(1));
    end
    if (cmd.scan_take && (row == '0 || rd_gt_best)) begin
      best_val <= rd_data;
    end
    if (cmd.left_edge) begin
      left_ok <= 1'b1;
      left_gt <= 1'b0;
    end else if (cmd.left_take) begin
      left_ok <= best_gt_rd;
      left_gt <= rd_gt_best;
    end
    if (cmd.right_edge) begin
      right_ok <= 1'b1;
    end else if (cmd.right_take) begin
      right_ok <= best_gt_rd;
    end
    if (cmd.hit_set) begin
      hit <= 1'b1;
    end else if (cmd.hit_clr) begin
      hit <= 1'b0;
    end
    if (cmd.res_load) begin
      out_row   <= hit ? best_row_w[gpf_pkg::IDX_W-1:0] : '0;
      out_col   <= hit ? mid_wide[gpf_pkg::IDX_W-1:0] : '0;
      out_found <= hit;
    end
  end

  always_comb begin
    status.range_empty = search_low >= search_high;
    status.scan_last   = RDW'(RDW'(row) + RDW'(1)) == rows_eff;
    status.mid_first   = mid == '0;
    status.mid_last    = mid_inc == cols_eff;
    status.left_ok     = left_ok;
    status.left_gt     = left_gt;
    status.right_ok    = right_ok;
    status.out_busy    = out_valid;
  end

endmodule

FILE: rtl/core/grid_peak_finder_core.sv
// Top level of the grid peak finder: ports, configuration registers, wiring.
//
// Usage:
//   Program num_rows (address 0) and num_cols (address 4) over the APB-style
//   port while the block is idle; both reset to 64. A value of 0 acts as 1,
//   a value above the build maximum acts as that maximum.
//   Stream the matrix into s_axis in row-major order, one element per item,
//   with tlast on the final element. Items are taken at one per cycle while loading.
//   After the tlast item the block searches the columns; s_axis_tready is
//   low for the whole search. Each search step scans the middle column row
//   by row through the single read port of the store, after the range
//   check, and then reads the two neighbors and takes the decision.
//   The result item appears on m_axis: tdata holds peak_row and peak_col,
//   tuser holds found; a miss reports row and column zero.
//   The result sits in an output register: loading of the next matrix starts
//   at once even while the receiver stalls, and the next search holds at its
//   end until the previous result has been taken.
//   Reset clears the load position, the control state and the output valid;
//   the store itself is not cleared and needs no clearing pass.
module grid_peak_finder_core #(
  parameter int ROWS_MAX = gpf_pkg::ROWS_MAX_DEF,
  parameter int COLS_MAX = gpf_pkg::COLS_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic        s_axis_tlast,   // last
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [5:0] peak_row, [11:6] peak_col, [15:12] zero
  output logic        m_axis_tuser    // [0] found
);

  logic [gpf_pkg::CFG_W-1:0] num_rows;
  logic [gpf_pkg::CFG_W-1:0] num_cols;
  logic                      cfg_we;
  logic [gpf_pkg::IDX_W-1:0] peak_row;
  logic [gpf_pkg::IDX_W-1:0] peak_col;
  gpf_pkg::cmd_t             cmd;
  gpf_pkg::status_t          status;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  // register select is address bit 2; low address bits are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= gpf_pkg::NUM_ROWS_RST;
      num_cols <= gpf_pkg::NUM_COLS_RST;
    end else if (cfg_we) begin
      if (paddr[2] == gpf_pkg::REG_NUM_ROWS) begin
        num_rows <= pwdata[gpf_pkg::CFG_W-1:0];
      end
      if (paddr[2] == gpf_pkg::REG_NUM_COLS) begin
        num_cols <= pwdata[gpf_pkg::CFG_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == gpf_pkg::REG_NUM_COLS) ? 32'(num_cols) : 32'(num_rows);

  gpf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  gpf_datapath #(
    .ROWS_MAX (ROWS_MAX),
    .COLS_MAX (COLS_MAX)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .num_rows_cfg (num_rows),
    .num_cols_cfg (num_cols),
    .in_value     (s_axis_tdata),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_row      (peak_row),
    .out_col      (peak_col),
    .out_found    (m_axis_tuser)
  );

  // pack result fields, lowest first, padded to two bytes
  assign m_axis_tdata = {4'b0000, peak_col, peak_row};

endmodule

FILE: rtl/core/gpf_checker.sv
// Port-level checks for the grid peak finder, bound to the top level.
module gpf_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // a miss reports row and column zero
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 16'h0000)
    else $error("miss with nonzero index");

  // the last item starts a search that blocks the input
  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input open right after last item");

  // a new result only comes out of a search, never during loading
  a_result_from_search: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result raised while loading");

endmodule

bind grid_peak_finder_core gpf_checker u_gpf_checker (.*);

FILE: sim/tb_grid_peak_finder_core.sv
`timescale 1ns / 100ps

// Self-checking testbench for grid_peak_finder_core with a scoreboard class and stream drivers.
module tb_grid_peak_finder_core;

  localparam int GRID_DEPTH   = gpf_pkg::ROWS_MAX_DEF * gpf_pkg::COLS_MAX_DEF;
  // Hard limit on the run, well above the slowest correct run.
  localparam int CYCLE_LIMIT  = 1_000_000;
  // Quiet cycles after the last result before a register write or the end.
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS  = 500;
  localparam int RANDOM_FRAMES = 10;

  typedef struct packed {
    logic [gpf_pkg::IDX_W-1:0] row;
    logic [gpf_pkg::IDX_W-1:0] col;
    logic                      found;
  } peak_t;

  // Mirror of the matrix store and register file; predicts one peak per tlast item.
  class peak_tracker;
    logic signed [gpf_pkg::VALUE_W-1:0] grid [GRID_DEPTH];
    int unsigned                        load_pos;
    int unsigned                        filled;
    logic [gpf_pkg::CFG_W-1:0]          rows_reg;
    logic [gpf_pkg::CFG_W-1:0]          cols_reg;
    peak_t                              pending_peaks [$];
    int                                 errors;
    int                                 n_items;
    int                                 n_results;
    int                                 n_found;

    function new();
      foreach (grid[i]) grid[i] = '0;
      load_pos  = 0;
      filled    = 0;
      rows_reg  = gpf_pkg::NUM_ROWS_RST;
      cols_reg  = gpf_pkg::NUM_COLS_RST;
      errors    = 0;
      n_items   = 0;
      n_results = 0;
      n_found   = 0;
    endfunction

    function void set_reg(logic idx, logic [gpf_pkg::CFG_W-1:0] v);
      if (idx == gpf_pkg::REG_NUM_ROWS) begin
        rows_reg = v;
      end else begin
        cols_reg = v;
      end
    endfunction

    function int clamp(int v, int limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return v;
    endfunction

    function int rows_used();
      return clamp(rows_reg, gpf_pkg::ROWS_MAX_DEF);
    endfunction

    function int cols_used();
      return clamp(cols_reg, gpf_pkg::COLS_MAX_DEF);
    endfunction

    function int pending();
      return pending_peaks.size();
    endfunction

    function logic signed [gpf_pkg::VALUE_W-1:0] at(int r, int c, int cols);
      return grid[(r * cols + c) % GRID_DEPTH];
    endfunction

    // Column binary search: first maximum of the middle column, strict test
    // against both neighbors, step toward a strictly larger left neighbor.
    function peak_t locate_peak();
      int                                 rows;
      int                                 cols;
      int                                 lo;
      int                                 hi;
      int                                 mid;
      int                                 best;
      logic signed [gpf_pkg::VALUE_W-1:0] cur;
      bit                                 left_low;
      bit                                 right_low;
      peak_t                              p;
      p    = '0;
      rows = rows_used();
      cols = cols_used();
      lo   = 0;
      hi   = cols;
      while (lo < hi) begin
        mid  = lo + (hi - 1 - lo) / 2;
        best = 0;
        for (int r = 1; r < rows; r++) begin
          if (at(best, mid, cols) < at(r, mid, cols)) best = r;
        end
        cur       = at(best, mid, cols);
        left_low  = (mid == 0) || (cur > at(best, mid - 1, cols));
        right_low = (mid == cols - 1) || (cur > at(best, mid + 1, cols));
        if (left_low && right_low) begin
          p.row   = best[gpf_pkg::IDX_W-1:0];
          p.col   = mid[gpf_pkg::IDX_W-1:0];
          p.found = 1'b1;
          return p;
        end else if (mid > 0 && at(best, mid - 1, cols) > cur) begin
          hi = mid;
        end else begin
          lo = mid + 1;
        end
      end
      return p;
    endfunction

    function void note_item(logic [gpf_pkg::VALUE_W-1:0] v, logic last);
      grid[load_pos] = v;
      if (load_pos >= filled) filled = load_pos + 1;
      load_pos = (load_pos + 1) % GRID_DEPTH;
      n_items++;
      if (last) begin
        load_pos = 0;
        pending_peaks.push_back(locate_peak());
      end
    endfunction

    function void check_result(peak_t got);
      peak_t want;
      n_results++;
      if (got.found) n_found++;
      if (pending_peaks.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, actual row %0d col %0d found %0d",
                 $time, got.row, got.col, got.found);
        return;
      end
      want = pending_peaks.pop_front();
      if (got.row !== want.row) begin
        errors++;
        $display("%0t: peak_row expected %0d, actual %0d", $time, want.row, got.row);
      end
      if (got.col !== want.col) begin
        errors++;
        $display("%0t: peak_col expected %0d, actual %0d", $time, want.col, got.col);
      end
      if (got.found !== want.found) begin
        errors++;
        $display("%0t: found expected %0d, actual %0d", $time, want.found, got.found);
      end
    endfunction
  endclass

  // Clock, reset and all block inputs start at known values.
  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;   // [31:0] value
  logic        s_axis_tlast  = 1'b0; // last
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [5:0] peak_row, [11:6] peak_col, [15:12] zero
  logic        m_axis_tuser;         // [0] found

  peak_tracker sb = new();

  int cycle_count = 0;
  int burst_left  = 0;
  bit steady      = 1'b0;
  int rx_mode     = 0;
  int rx_left     = 0;

  grid_peak_finder_core dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk = ~clk;

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, sb.pending());
      $display("grid_peak_finder_core verification failed");
      $finish;
    end
  end

  // Receiver stall pattern: switch among four modes, each held for a random stretch, so stalls
  // land at every point of the result handshake, with fully ready stretches too.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= $urandom_range(0, 1);
      2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (rx_left[4:0] < 5);
    endcase
  end

  // Monitor: sample pre-edge values of every handshake and feed the scoreboard.
  // Register writes go in first so a same-edge item sees the new setting.
  always @(posedge clk) begin
    peak_t seen;
    if (!rst) begin
      if (psel && penable && pwrite && pready) begin
        sb.set_reg(paddr[2], pwdata[gpf_pkg::CFG_W-1:0]);
      end
      if (s_axis_tvalid && s_axis_tready) sb.note_item(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        seen.row   = m_axis_tdata[5:0];
        seen.col   = m_axis_tdata[11:6];
        seen.found = m_axis_tuser;
        sb.check_result(seen);
      end
    end
  end

  // Drop valid and wait until every expected result is out, then idle a while.
  task automatic settle(input int quiet);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (quiet) @(posedge clk);
  endtask

  // Two-phase register write: setup cycle, then access cycle.
  // Upper data bits are random; only the low seven bits matter.
  task automatic write_reg(input logic idx, input int unsigned v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ($urandom & 32'hFFFF_FF80) | (v & 32'h7F);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_dims(input int unsigned rows_w, input int unsigned cols_w);
    settle(DRAIN_CYCLES);
    write_reg(gpf_pkg::REG_NUM_ROWS, rows_w);
    write_reg(gpf_pkg::REG_NUM_COLS, cols_w);
  endtask

  // Hold valid low for a gap with junk on the data lines; n sets its length.
  task automatic idle_gap(input int n);
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= $urandom;
    s_axis_tlast  <= $urandom_range(0, 1);
    repeat (n) @(posedge clk);
  endtask

  // Present one item and hold it until the block takes it.
  task automatic send_item(input logic [31:0] v, input logic last);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Send in bursts of random length; insert a gap before each burst unless steady.
  task automatic push_item(input logic [31:0] v, input logic last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (!steady) idle_gap($urandom_range(1, 6));
    end
    send_item(v, last);
    burst_left--;
  endtask

  // Value styles: narrow range to force ties, full random, or extremes mixed in.
  function automatic logic [31:0] pick_value(input int style);
    case (style)
      0: return $urandom_range(0, 4) - 2;
      1: return $urandom;
      default: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return $urandom_range(0, 8) - 4;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  task automatic send_frame(input int len, input int style);
    for (int i = 0; i < len; i++) push_item(pick_value(style), i == len - 1);
  endtask

  // Random geometry, including zero and above-maximum register values.
  task automatic pick_dims();
    int unsigned rw;
    int unsigned cw;
    case ($urandom_range(0, 9))
      0: begin
        rw = $urandom_range(0, 1) ? 0 : $urandom_range(1, 4);
        cw = (rw == 0) ? $urandom_range(0, 8) : 0;
      end
      1: begin
        rw = $urandom_range(64, 127);
        cw = $urandom_range(1, 3);
      end
      2: begin
        rw = $urandom_range(1, 2);
        cw = $urandom_range(64, 127);
      end
      default: begin
        rw = $urandom_range(1, 6);
        cw = $urandom_range(1, 8);
      end
    endcase
    set_dims(rw, cw);
  endtask

  initial begin
    int frames;
    int rand_items;
    int cells;
    int len;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: small matrices with hand-checked outcomes.
    steady = 1'b1;
    // Zero row count acts as one; a single entry is a peak whatever its value.
    set_dims(0, 1);
    push_item(32'h8000_0000, 1'b1);
    push_item(32'h7FFF_FFFF, 1'b1);
    // Flat row: no strict peak, the range runs empty.
    set_dims(1, 3);
    push_item(32'd5, 1'b0);
    push_item(32'd5, 1'b0);
    push_item(32'd5, 1'b1);
    // Rising row: step right to the edge column.
    push_item(32'd1, 1'b0);
    push_item(32'd2, 1'b0);
    push_item(32'd3, 1'b1);
    // Falling row: step left to column zero.
    push_item(32'd3, 1'b0);
    push_item(32'd2, 1'b0);
    push_item(32'd1, 1'b1);
    // Column maximum in the second row, extremes of the value range.
    steady = 1'b0;
    set_dims(2, 2);
    push_item(32'h8000_0000, 1'b0);
    push_item(32'h7FFF_FFFF, 1'b0);
    push_item(32'h0000_0000, 1'b0);
    push_item(32'hFFFF_FFFF, 1'b1);
    // Tie in the middle column: the first maximum row wins.
    set_dims(3, 2);
    push_item(32'd7, 1'b0);
    push_item(32'd0, 1'b0);
    push_item(32'd7, 1'b0);
    push_item(32'd9, 1'b0);
    push_item(32'd1, 1'b0);
    push_item(32'd1, 1'b1);

    // Random part: mostly well-formed frames, some cut short, some overlong.
    // A frame is cut short only when the store already holds every entry the
    // search will read.
    frames     = 0;
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS || frames < RANDOM_FRAMES) begin
      if (frames % 4 == 0) begin
        pick_dims();
      end else if ($urandom_range(0, 5) == 0) begin
        // hold off until the block has handed back every result
        settle(0);
      end
      steady = ($urandom_range(0, 3) == 0);
      cells  = sb.rows_used() * sb.cols_used();
      case ($urandom_range(0, 9))
        0:       len = (sb.filled >= cells) ? $urandom_range(1, cells) : cells;
        1:       len = cells + $urandom_range(1, 5);
        default: len = cells;
      endcase
      send_frame(len, $urandom_range(0, 2));
      rand_items += len;
      frames++;
    end

    settle(DRAIN_CYCLES * 4);
    $display("streamed %0d items and checked %0d searches (%0d peaks, %0d misses)",
             sb.n_items, sb.n_results, sb.n_found, sb.n_results - sb.n_found);
    $display("geometries up to 64 rows or 64 columns incl. zero and oversized counts, early and late tlast");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("grid_peak_finder_core verification clean");
    end else begin
      $display("grid_peak_finder_core verification failed");
    end
    $finish;
  end

endmodule
